### design/upsc_pkg.sv
// Shared types and constants for the pixel replication upscaler.
package upsc_pkg;

  localparam int PixW   = 64;
  localparam int AddrW  = 30;
  localparam int ScaleW = 4;
  localparam int SizeW  = 13;
  localparam int PaddrW = 4;
  localparam int PdataW = 32;

  typedef enum logic [1:0] {
    REG_SCALE  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BASE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [ScaleW-1:0] scale;
    logic [SizeW-1:0]  width;
    logic [SizeW-1:0]  height;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic base;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic block_done;
  } status_t;

endpackage

### design/upsc_regs.sv
// APB configuration registers with clamping of written values.
module upsc_regs import upsc_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_SCALE  = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [ScaleW-1:0] scale_q, scale_d;
  logic [SizeW-1:0]  width_q, width_d;
  logic [SizeW-1:0]  height_q, height_d;
  logic              wr_en;
  logic [1:0]        idx;
  logic [ScaleW-1:0] wr_scale;
  logic [SizeW-1:0]  wr_size;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign idx      = paddr[3:2];
  assign wr_scale = pwdata[ScaleW-1:0];
  assign wr_size  = pwdata[SizeW-1:0];

  always_comb begin
    scale_d  = scale_q;
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      case (idx)
        REG_SCALE: begin
          if (wr_scale != '0) begin
            scale_d = (int'(wr_scale) > MAX_SCALE) ? ScaleW'(MAX_SCALE) : wr_scale;
          end
        end
        REG_WIDTH: begin
          if (wr_size == '0) width_d = SizeW'(1);
          else if (int'(wr_size) > MAX_WIDTH) width_d = SizeW'(MAX_WIDTH);
          else width_d = wr_size;
        end
        REG_HEIGHT: begin
          if (wr_size == '0) height_d = SizeW'(1);
          else if (int'(wr_size) > MAX_HEIGHT) height_d = SizeW'(MAX_HEIGHT);
          else height_d = wr_size;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= ScaleW'(1);
      width_q  <= SizeW'(1);
      height_q <= SizeW'(1);
    end else begin
      scale_q  <= scale_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    case (idx)
      REG_SCALE:  prdata = PdataW'(scale_q);
      REG_WIDTH:  prdata = PdataW'(width_q);
      REG_HEIGHT: prdata = PdataW'(height_q);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = '{scale: scale_q, width: width_q, height: height_q};

endmodule

### design/upsc_ctrl.sv
// Controller state machine sequencing load, base address and word emission.
module upsc_ctrl import upsc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_BASE;
      ST_BASE: state_d = ST_EMIT;
      ST_EMIT: if (out_ready_i && status_i.block_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_BASE: cmd_o.base = 1'b1;
      ST_EMIT: begin
        out_valid_o = 1'b1;
        cmd_o.step  = out_ready_i && !status_i.block_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && status_i.block_done) |=> (in_ready_o && !out_valid_o))
    else $error("controller did not return to idle after last word of block");

endmodule

### design/upsc_dp.sv
// Datapath: source counters, block address generation and output word.
module upsc_dp import upsc_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_SCALE  = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  cmd_t             cmd_i,
  input  logic [PixW-1:0]  pixel_i,
  output status_t          status_o,
  output logic [AddrW-1:0] write_address_o,
  output logic [PixW-1:0]  out_pixel_o,
  output logic             block_last_o,
  output logic             frame_last_o
);

  localparam int ColW = (MAX_WIDTH >= 8192) ? SizeW :
                        ((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1);
  localparam int RowW = (MAX_HEIGHT >= 8192) ? SizeW :
                        ((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1);
  localparam int DW   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int XsW  = ColW + ScaleW;
  localparam int YsW  = RowW + ScaleW;
  localparam int OwW  = SizeW + ScaleW;

  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [DW-1:0]     dx_q, dx_d;
  logic [DW-1:0]     dy_q, dy_d;
  logic [XsW-1:0]    xs_q;
  logic [YsW-1:0]    ys_q;
  logic [OwW-1:0]    ow_q;
  logic [AddrW-1:0]  line_q, line_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [PixW-1:0]   pix_q;
  logic              frame_q;
  logic              last_col, last_row;
  logic              dx_end, dy_end;
  logic [ScaleW-1:0] scale_m1;

  assign scale_m1 = cfg_i.scale - ScaleW'(1);
  assign last_col = (SizeW'(col_q) + SizeW'(1)) >= cfg_i.width;
  assign last_row = (SizeW'(row_q) + SizeW'(1)) >= cfg_i.height;
  assign dx_end   = ScaleW'(dx_q) == scale_m1;
  assign dy_end   = ScaleW'(dy_q) == scale_m1;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.load) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_comb begin
    dx_d   = dx_q;
    dy_d   = dy_q;
    line_d = line_q;
    addr_d = addr_q;
    if (cmd_i.base) begin
      dx_d   = '0;
      dy_d   = '0;
      line_d = 30'(30'(ys_q) * 30'(ow_q)) + 30'(xs_q);
      addr_d = line_d;
    end else if (cmd_i.step) begin
      if (dx_end) begin
        dx_d   = '0;
        dy_d   = dy_q + DW'(1);
        line_d = line_q + AddrW'(ow_q);
        addr_d = line_d;
      end else begin
        dx_d   = dx_q + DW'(1);
        addr_d = addr_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      dx_q  <= '0;
      dy_q  <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      dx_q  <= dx_d;
      dy_q  <= dy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_q   <= pixel_i;
      frame_q <= last_col && last_row;
      xs_q    <= XsW'(col_q) * XsW'(cfg_i.scale);
      ys_q    <= YsW'(row_q) * YsW'(cfg_i.scale);
      ow_q    <= OwW'(cfg_i.width) * OwW'(cfg_i.scale);
    end
    line_q <= line_d;
    addr_q <= addr_d;
  end

  assign status_o.block_done = dx_end && dy_end;
  assign write_address_o     = addr_q;
  assign out_pixel_o         = pix_q;
  assign block_last_o        = dx_end && dy_end;
  assign frame_last_o        = frame_q;

  a_dx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (ScaleW'(dx_q) <= scale_m1 && ScaleW'(dy_q) <= scale_m1))
    else $error("block offset beyond scale");

  a_addr_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && !dx_end) |=> addr_q == $past(addr_q) + AddrW'(1))
    else $error("address did not advance by one within a line");

  a_line_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && dx_end) |=> (addr_q == line_q && dx_q == '0))
    else $error("address did not move to next output line");

endmodule

### design/pixel_replication_upscaler_core.sv
// Top level of the pixel replication upscaler.
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------------
//  in      | in_valid_i / in_ready_o    | pixel_i
//  out     | out_valid_o / out_ready_i  | write_address_o, out_pixel_o,
//          |                            | block_last_o, frame_last_o
//  cfg     | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// Each pixel is handled in order: the load forms the block origin
// products, the base state does the origin address multiply-add, then
// the address walker gives one word per cycle while out_ready_i is high.
// Reset: scale, width and height read 1; column and row counters clear.
// A stalled out_ready_i holds the current word; no new pixel is taken
// until the last word of the block is accepted.
module pixel_replication_upscaler_core import upsc_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_SCALE  = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [PixW-1:0]   pixel_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [AddrW-1:0]  write_address_o,
  output logic [PixW-1:0]   out_pixel_o,
  output logic              block_last_o,
  output logic              frame_last_o
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  upsc_regs #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_SCALE (MAX_SCALE)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  upsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  upsc_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_SCALE (MAX_SCALE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .pixel_i        (pixel_i),
    .status_o       (status),
    .write_address_o(write_address_o),
    .out_pixel_o    (out_pixel_o),
    .block_last_o   (block_last_o),
    .frame_last_o   (frame_last_o)
  );

endmodule

### tb/testbench.sv
// Self-checking testbench for pixel_replication_upscaler_core with a scoreboard class.
module testbench import upsc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxWidth   = 4096;
  localparam int MaxHeight  = 4096;
  localparam int MaxScale   = 8;
  localparam int CycleLimit = 400000;
  localparam int RandPixels = 255;
  localparam logic [1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [PixW-1:0]  pix;
    logic             blk;
    logic             frm;
  } write_word_t;

  class upscale_scoreboard;
    write_word_t writes_due[$];
    logic [ScaleW-1:0] scale;
    logic [SizeW-1:0]  width;
    logic [SizeW-1:0]  height;
    logic [11:0]       col;
    logic [11:0]       row;
    int unsigned mismatches;
    int unsigned pixels_noted;
    int unsigned words_seen;
    int unsigned frames_seen;

    function new();
      scale = ScaleW'(1);
      width = SizeW'(1);
      height = SizeW'(1);
      col = '0;
      row = '0;
      mismatches = 0;
      pixels_noted = 0;
      words_seen = 0;
      frames_seen = 0;
    endfunction

    function int pending();
      return writes_due.size();
    endfunction

    function void note_mismatch(string msg);
      if (mismatches < 10) $display("MISMATCH: %s", msg);
      mismatches++;
    endfunction

    function logic [SizeW-1:0] clamp_size(logic [SizeW-1:0] v, int maxv);
      if (v == '0) return SizeW'(1);
      if (int'(v) > maxv) return SizeW'(maxv);
      return v;
    endfunction

    function void set_reg(logic [1:0] idx, logic [PdataW-1:0] val);
      case (idx)
        REG_SCALE: begin
          if (val[ScaleW-1:0] != '0)
            scale = (int'(val[ScaleW-1:0]) > MaxScale) ? ScaleW'(MaxScale) : val[ScaleW-1:0];
        end
        REG_WIDTH:  width = clamp_size(val[SizeW-1:0], MaxWidth);
        REG_HEIGHT: height = clamp_size(val[SizeW-1:0], MaxHeight);
        default: ;
      endcase
    endfunction

    function logic [PdataW-1:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_SCALE:  return PdataW'(scale);
        REG_WIDTH:  return PdataW'(width);
        REG_HEIGHT: return PdataW'(height);
        default:    return '0;
      endcase
    endfunction

    function void compare_reg(logic [1:0] idx, logic [PdataW-1:0] got);
      if (got !== reg_value(idx))
        note_mismatch($sformatf("register %0d read %h, expected %h", idx, got, reg_value(idx)));
    endfunction

    function void note_pixel(logic [PixW-1:0] px);
      write_word_t w;
      logic [63:0] out_w;
      logic [63:0] y;
      logic [63:0] x;
      logic [63:0] a;
      logic last_col;
      logic last_row;
      int dy;
      int dx;
      last_col = ({1'b0, col} + 13'd1) >= width;
      last_row = ({1'b0, row} + 13'd1) >= height;
      out_w = 64'(width) * 64'(scale);
      for (dy = 0; dy < int'(scale); dy++) begin
        for (dx = 0; dx < int'(scale); dx++) begin
          y = 64'(row) * 64'(scale) + 64'(dy);
          x = 64'(col) * 64'(scale) + 64'(dx);
          a = y * out_w + x;
          w.addr = a[AddrW-1:0];
          w.pix = px;
          w.blk = (dy == int'(scale) - 1) && (dx == int'(scale) - 1);
          w.frm = last_col && last_row;
          writes_due.push_back(w);
        end
      end
      if (last_col && last_row) frames_seen++;
      if (last_col) begin
        col = '0;
        row = last_row ? '0 : row + 12'd1;
      end else begin
        col = col + 12'd1;
      end
      pixels_noted++;
    endfunction

    function void check_write(logic [AddrW-1:0] addr, logic [PixW-1:0] px, logic blk,
                              logic frm);
      write_word_t due;
      words_seen++;
      if (writes_due.size() == 0) begin
        note_mismatch($sformatf("unexpected write addr %h pix %h last %b/%b", addr, px, blk,
                                frm));
      end else begin
        due = writes_due.pop_front();
        if (addr !== due.addr || px !== due.pix || blk !== due.blk || frm !== due.frm)
          note_mismatch($sformatf(
              "expected addr %h pix %h last %b/%b, got addr %h pix %h last %b/%b",
              due.addr, due.pix, due.blk, due.frm, addr, px, blk, frm));
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [PixW-1:0]   pixel_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [AddrW-1:0]  write_address_o;
  logic [PixW-1:0]   out_pixel_o;
  logic              block_last_o;
  logic              frame_last_o;

  bit no_idle = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned settings = 0;
  upscale_scoreboard sb = new();

  pixel_replication_upscaler_core #(
    .MAX_WIDTH (MaxWidth),
    .MAX_HEIGHT(MaxHeight),
    .MAX_SCALE (MaxScale)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_i        (pixel_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_address_o(write_address_o),
    .out_pixel_o    (out_pixel_o),
    .block_last_o   (block_last_o),
    .frame_last_o   (frame_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(0, 99) >= 37);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_pixel(pixel_i);
      if (out_valid_o && out_ready_i)
        sb.check_write(write_address_o, out_pixel_o, block_last_o, frame_last_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d writes outstanding", cycle_count,
               sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [PdataW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reg_read(input logic [1:0] idx, output logic [PdataW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    val = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [PdataW-1:0] scale_w, input logic [PdataW-1:0] width_w,
                           input logic [PdataW-1:0] height_w);
    logic [PdataW-1:0] got;
    reg_write(REG_SCALE, scale_w);
    reg_write(REG_WIDTH, width_w);
    reg_write(REG_HEIGHT, height_w);
    reg_read(REG_SCALE, got);
    sb.compare_reg(REG_SCALE, got);
    reg_read(REG_WIDTH, got);
    sb.compare_reg(REG_WIDTH, got);
    reg_read(REG_HEIGHT, got);
    sb.compare_reg(REG_HEIGHT, got);
    settings++;
  endtask

  task automatic send_pixel(input logic [PixW-1:0] px);
    while (!no_idle && $urandom_range(0, 99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i <= px;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // hold the sender until every expected word has been taken
  task automatic drain_writes();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [PdataW-1:0] rand_size_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 1;
      2: return MaxWidth;
      3: return $urandom_range(MaxWidth + 1, 8191);
      4: return $urandom;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  initial begin
    logic [PdataW-1:0] scale_w;
    int rand_sent;
    int phase;
    int n;
    logic [PixW-1:0] px;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pixel('0);
    send_pixel('1);
    send_pixel({4{16'hAAAA}});
    send_pixel({4{16'h5555}});
    drain_writes();

    // zero writes: scale is kept, sizes read back as one
    configure('0, '0, '0);
    reg_write(RegUnused, 32'hFFFF_FFFF);
    send_pixel(64'hFFFF_0000_FFFF_0000);
    drain_writes();

    // oversized writes clamp to the maxima
    configure(32'd15, 32'd8191, 32'd5000);
    send_pixel(64'h0000_FFFF_0000_FFFF);
    send_pixel(64'h8000_0001_8000_0001);
    drain_writes();

    // column already past the new last column
    configure(MaxScale, 32'd2, 32'd2);
    repeat (4) send_pixel({$urandom, $urandom});
    drain_writes();

    configure(32'd3, 32'd8, 32'd4);
    repeat (5) send_pixel({$urandom, $urandom});
    drain_writes();

    // shrink both sizes mid frame
    configure(32'd3, 32'd3, 32'd1);
    repeat (3) send_pixel({$urandom, $urandom});
    drain_writes();

    configure(32'd2, MaxWidth, 32'd1);
    repeat (2) send_pixel({$urandom, $urandom});

    rand_sent = 0;
    phase = 0;
    while (rand_sent < RandPixels) begin
      drain_writes();
      no_idle = (phase == 4);
      case ($urandom_range(0, 7))
        0: scale_w = '0;
        1: scale_w = 1;
        2: scale_w = MaxScale;
        3: scale_w = $urandom_range(MaxScale + 1, 15);
        4: scale_w = $urandom;
        default: scale_w = $urandom_range(1, 4);
      endcase
      configure(scale_w, rand_size_word(), rand_size_word());
      if ($urandom_range(0, 3) == 0) reg_write(RegUnused, $urandom);
      n = no_idle ? 40 : $urandom_range(4, 24);
      repeat (n) begin
        if ($urandom_range(0, 24) == 0) drain_writes();
        case ($urandom_range(0, 9))
          0: px = '0;
          1: px = '1;
          default: px = {$urandom, $urandom};
        endcase
        send_pixel(px);
        rand_sent++;
      end
      phase++;
    end
    no_idle = 1'b0;

    drain_writes();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d pixels, %0d writes and %0d frame ends over %0d register settings",
             sb.pixels_noted, sb.words_seen, sb.frames_seen, settings);
    $display("Scales 1 to 8, clamped and ignored writes, mid-frame size changes; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
